>>> hdl/velocity_friction_integrator_unit_assert.svh
// assertion macros for the velocity friction integrator
`ifndef VELOCITY_FRICTION_INTEGRATOR_UNIT_ASSERT_SVH
`define VELOCITY_FRICTION_INTEGRATOR_UNIT_ASSERT_SVH
// a condition that implies another in the same cycle
`define VFI_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// a condition that implies another in the next cycle
`define VFI_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

>>> hdl/vfi_pkg.sv
// shared types and constants of the velocity friction integrator
package vfi_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int TS_FRAC = 16;
    localparam int N_CFG = 6;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_ADD_VEL = 2'd1,
        REQ_SET_POS = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        CFG_GX = 3'd0, CFG_GY = 3'd1, CFG_GZ = 3'd2,
        CFG_FX = 3'd3, CFG_FY = 3'd4, CFG_FZ = 3'd5
    } cfg_idx_t;

    // datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_GRAV, OP_ADDV, OP_SETP,
        OP_SQ_V, OP_SQ_F, OP_SQRT, OP_DIV, OP_POS
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] lane;   // component, or 0 speed / 1 friction for sqrt
        logic       first;  // start of an iterative op
    } cmd_t;

    typedef struct packed {
        logic done;         // iterative op finished
    } sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

>>> hdl/velocity_friction_integrator_unit.sv
// top level of the velocity friction integrator
// one item is worked on at a time and its result waits in the output until taken;
// the tick time is set by the bit-serial square root (two runs) and the
// bit-serial divider (three runs)
module velocity_friction_integrator_unit #(
    parameter int FRAC_BITS = vfi_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration write port
    input  logic         cfg_we,
    input  logic [2:0]   cfg_idx,
    input  logic [31:0]  cfg_data,
    // input item
    input  logic         s_tvalid,
    output logic         s_tready,
    // req_type[1:0]
    input  logic [1:0]   s_tuser,
    // time_step[19:0], on_ground[20], value_x[52:21], value_y[84:53],
    // value_z[116:85], scale_by_time[117], zero fill above
    input  logic [119:0] s_tdata,
    // result item
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z from bit 0 up
    output logic [191:0] m_tdata
);
    vfi_pkg::cmd_t cmd;
    vfi_pkg::sts_t sts;
    logic busy;
    logic signed [31:0] vals [3];
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];

    assign s_tready = !busy;
    assign vals[0] = s_tdata[52:21];
    assign vals[1] = s_tdata[84:53];
    assign vals[2] = s_tdata[116:85];

    // the controller latches request kind, datapath latches operands on load
    logic [19:0] dt_hold;
    logic        scale_hold;
    logic signed [31:0] val_hold [3];
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            dt_hold <= s_tdata[19:0];
            scale_hold <= s_tdata[117];
            for (int i = 0; i < 3; i++) val_hold[i] <= vals[i];
        end
    end

    vfi_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_tvalid && s_tready), .in_req(s_tuser), .in_ground(s_tdata[20]),
        .out_fire(m_tvalid && m_tready), .busy(busy), .out_valid(m_tvalid),
        .cmd(cmd), .sts(sts)
    );

    vfi_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .in_dt(dt_hold), .in_scale(scale_hold), .in_val(val_hold),
        .pos(pos), .vel(vel)
    );

    assign m_tdata = {vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};

    // zero fill bits of the input item
    logic unused;
    assign unused = ^s_tdata[119:118];
endmodule

>>> hdl/vfi_datapath.sv
// datapath: state vectors, a shared multiplier, iterative sqrt and divider
module vfi_datapath #(
    parameter int FRAC_BITS = vfi_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vfi_pkg::cmd_t       cmd,
    output vfi_pkg::sts_t       sts,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_idx,
    input  logic [31:0]         cfg_data,
    input  logic [19:0]         in_dt,
    input  logic                in_scale,
    input  logic signed [31:0]  in_val [3],
    output logic signed [31:0]  pos [3],
    output logic signed [31:0]  vel [3]
);
    localparam int YC = ((1 << FRAC_BITS) + 9999) / 10000;

    logic signed [31:0] cfg_reg [6];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] val_reg [3];
    logic [19:0]        dt_reg;
    logic               scale_reg;
    logic [65:0]        acc_reg;      // sum of squares
    logic [32:0]        sp_reg, fr_reg, ns_reg;
    // sqrt state
    logic [65:0]        rem_reg;
    logic [65:0]        res_reg;
    logic [5:0]         cnt_reg;
    // divider state
    logic [65:0]        num_reg;
    logic [32:0]        drem_reg;
    logic [65:0]        quo_reg;

    // one shared multiplier: 33 x 33 squares or 32 x 20 step products
    logic signed [33:0] ma, mb;
    logic signed [67:0] mp;
    logic signed [31:0] mc;
    logic signed [32:0] mabs;
    always_comb
    begin
        case (cmd.op)
            vfi_pkg::OP_GRAV: mc = cfg_reg[cmd.lane];
            vfi_pkg::OP_ADDV: mc = val_reg[cmd.lane];
            vfi_pkg::OP_SQ_F: mc = cfg_reg[3 + cmd.lane];
            default:          mc = vel_reg[cmd.lane];
        endcase
        mabs = mc[31] ? -33'(mc) : 33'(mc);
        if (cmd.op == vfi_pkg::OP_SQ_V || cmd.op == vfi_pkg::OP_SQ_F)
        begin
            ma = 34'(mabs);
            mb = 34'(mabs);
        end
        else
        begin
            ma = 34'(mc);
            mb = $signed({14'd0, dt_reg});
        end
        mp = ma * mb;
    end
    logic signed [67:0] rnd;
    logic signed [31:0] stepped;
    assign rnd = (mp + 68'sd32768) >>> vfi_pkg::TS_FRAC;
    assign stepped = vfi_pkg::sat32(rnd[65:0]);

    logic [65:0] trial;
    assign trial = res_reg + (66'd1 << {cnt_reg, 1'b0});
    logic [32:0] dsh;
    logic        dge;
    assign dsh = {drem_reg[31:0], num_reg[65]};
    assign dge = ({drem_reg[32], dsh} >= {1'b0, sp_reg});
    // quotient including the bit found this step
    logic [65:0] quo_next;
    assign quo_next = {quo_reg[64:0], dge};

    // last step of an iterative op
    assign sts.done = !cmd.first && cnt_reg == 6'd0
                      && (cmd.op == vfi_pkg::OP_SQRT || cmd.op == vfi_pkg::OP_DIV);

    logic signed [31:0] dres;
    logic signed [33:0] fq;
    logic [66:0] fr_full;
    logic [66:0] drop_full;
    assign fq = quo_reg[33:0] > 34'd2147483648 ? 34'sd2147483648 : $signed(quo_reg[33:0]);
    assign fr_full = 67'(fr_reg) * 67'(dt_reg);
    // friction drop kept at full width, it is not saturated
    assign drop_full = (fr_full + 67'd32768) >> vfi_pkg::TS_FRAC;
    always_comb
    begin
        if (sp_reg == '0)
            dres = '0;
        else if (quo_next > 66'd2147483647)
            dres = vel_reg[cmd.lane][31] ? 32'sh80000000 : 32'sh7fffffff;
        else
            dres = vel_reg[cmd.lane][31] ? -32'(quo_next[31:0]) : 32'(quo_next[31:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++) cfg_reg[i] <= '0;
            for (int i = 0; i < 3; i++)
            begin
                vel_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we && cfg_idx < 3'(vfi_pkg::N_CFG))
                cfg_reg[cfg_idx] <= cfg_data;
            case (cmd.op)
                vfi_pkg::OP_GRAV:
                    vel_reg[cmd.lane] <= vfi_pkg::sat32(66'(vel_reg[cmd.lane]) + 66'(stepped));
                vfi_pkg::OP_ADDV:
                    vel_reg[cmd.lane] <= vfi_pkg::sat32(66'(vel_reg[cmd.lane]) +
                        66'(scale_reg ? stepped : val_reg[cmd.lane]));
                vfi_pkg::OP_SETP:
                    pos_reg[cmd.lane] <= val_reg[cmd.lane];
                vfi_pkg::OP_POS:
                    pos_reg[cmd.lane] <= vfi_pkg::sat32(66'(pos_reg[cmd.lane]) + 66'(stepped));
                vfi_pkg::OP_DIV:
                    if (!cmd.first && cnt_reg == 6'd0)
                    begin
                        if (cmd.lane == 2'd1)
                        begin
                            if ((vel_reg[1][31] ? -33'(vel_reg[1]) : 33'(vel_reg[1]))
                                < 33'(YC))
                                vel_reg[1] <= '0;
                        end
                        else
                            vel_reg[cmd.lane] <= dres;
                    end
                default: ;
            endcase
        end
    end

    logic [65:0] dividend;
    assign dividend = 66'(mabs) * 66'(ns_reg);

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            vfi_pkg::OP_LOAD:
            begin
                dt_reg <= in_dt;
                scale_reg <= in_scale;
                for (int i = 0; i < 3; i++) val_reg[i] <= in_val[i];
                acc_reg <= '0;
            end
            vfi_pkg::OP_SQ_V, vfi_pkg::OP_SQ_F:
                acc_reg <= (cmd.first ? 66'd0 : acc_reg) + mp[65:0];
            vfi_pkg::OP_SQRT:
                if (cmd.first)
                begin
                    rem_reg <= acc_reg;
                    res_reg <= '0;
                    cnt_reg <= 6'd32;
                end
                else
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_reg <= rem_reg - trial;
                        res_reg <= (res_reg >> 1) + (66'd1 << {cnt_reg, 1'b0});
                    end
                    else
                        res_reg <= res_reg >> 1;
                    if (cnt_reg == 6'd0)
                    begin
                        acc_reg <= '0;
                        if (cmd.lane == 2'd0)
                            sp_reg <= (rem_reg >= trial) ? 33'((res_reg >> 1) + 66'd1)
                                                        : 33'(res_reg >> 1);
                        else
                        begin
                            fr_reg <= (rem_reg >= trial) ? 33'((res_reg >> 1) + 66'd1)
                                                        : 33'(res_reg >> 1);
                        end
                    end
                    else
                        cnt_reg <= cnt_reg - 6'd1;
                end
            vfi_pkg::OP_DIV:
                if (cmd.first)
                begin
                    // numerator stays below 2^64, so the top two bits are dropped
                    num_reg <= (dividend + 66'(sp_reg >> 1)) << 2;
                    drem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= 6'd63;
                end
                else
                begin
                    num_reg <= num_reg << 1;
                    drem_reg <= dge ? 33'({drem_reg[32], dsh} - {1'b0, sp_reg}) : dsh;
                    quo_reg <= quo_next;
                    if (cnt_reg != 6'd0)
                        cnt_reg <= cnt_reg - 6'd1;
                end
            vfi_pkg::OP_NOP:
                // new speed after the friction drop, floor of zero
                ns_reg <= (67'(sp_reg) > drop_full) ? 33'(67'(sp_reg) - drop_full) : '0;
            default: ;
        endcase
    end

    assign pos = pos_reg;
    assign vel = vel_reg;
    logic unused;
    assign unused = ^{fq, rnd[67:66]};
endmodule

>>> hdl/vfi_ctrl.sv
// controller: sequences the datapath for each request
module vfi_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic [1:0]     in_req,
    input  logic           in_ground,
    input  logic           out_fire,
    output logic           busy,
    output logic           out_valid,
    output vfi_pkg::cmd_t  cmd,
    input  vfi_pkg::sts_t  sts
);
    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_GRAV, S_ADDV, S_SETP, S_SQV, S_SQRTV, S_SQF, S_SQRTF,
        S_DROP, S_DIV, S_POS, S_OUT
    } state_t;

    state_t state_reg;
    logic [1:0] lane_reg, req_reg;
    logic first_reg, ground_reg, wait_reg;

    always_comb
    begin
        cmd.lane = lane_reg;
        cmd.first = first_reg;
        case (state_reg)
            S_LOAD:  cmd.op = vfi_pkg::OP_LOAD;
            S_GRAV:  cmd.op = vfi_pkg::OP_GRAV;
            S_ADDV:  cmd.op = vfi_pkg::OP_ADDV;
            S_SETP:  cmd.op = vfi_pkg::OP_SETP;
            S_SQV:   cmd.op = vfi_pkg::OP_SQ_V;
            S_SQF:   cmd.op = vfi_pkg::OP_SQ_F;
            S_SQRTV, S_SQRTF: cmd.op = vfi_pkg::OP_SQRT;
            S_DIV:   cmd.op = wait_reg ? vfi_pkg::OP_NOP : vfi_pkg::OP_DIV;
            S_POS:   cmd.op = vfi_pkg::OP_POS;
            default: cmd.op = vfi_pkg::OP_NOP;
        endcase
        if (state_reg == S_SQRTF) cmd.lane = 2'd1;
        if (state_reg == S_SQRTV) cmd.lane = 2'd0;
    end

    assign busy = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lane_reg <= '0;
            req_reg <= '0;
            first_reg <= 1'b0;
            ground_reg <= 1'b0;
            wait_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (in_fire)
                    begin
                        req_reg <= in_req;
                        ground_reg <= in_ground;
                        state_reg <= S_LOAD;
                    end
                S_LOAD:
                begin
                    lane_reg <= 2'd0;
                    first_reg <= 1'b1;
                    case (req_reg)
                        vfi_pkg::REQ_TICK:    state_reg <= ground_reg ? S_SQV : S_GRAV;
                        vfi_pkg::REQ_ADD_VEL: state_reg <= S_ADDV;
                        vfi_pkg::REQ_SET_POS: state_reg <= S_SETP;
                        default:              state_reg <= S_OUT;
                    endcase
                end
                S_GRAV, S_ADDV, S_SETP, S_SQV, S_SQF, S_POS:
                begin
                    first_reg <= (lane_reg == 2'd2);
                    lane_reg <= (lane_reg == 2'd2) ? 2'd0 : lane_reg + 2'd1;
                    if (lane_reg == 2'd2)
                        case (state_reg)
                            S_GRAV:  state_reg <= S_SQV;
                            S_SQV:   state_reg <= S_SQRTV;
                            S_SQF:   state_reg <= S_SQRTF;
                            default: state_reg <= S_OUT;
                        endcase
                    else
                        first_reg <= 1'b0;
                    if (state_reg == S_SQV && lane_reg != 2'd2) first_reg <= 1'b0;
                end
                S_SQRTV, S_SQRTF:
                begin
                    first_reg <= 1'b0;
                    if (sts.done)
                    begin
                        first_reg <= 1'b1;
                        lane_reg <= 2'd0;
                        state_reg <= (state_reg == S_SQRTV) ? S_SQF : S_DROP;
                    end
                end
                S_DROP:
                begin
                    // an idle step computes friction drop and new speed
                    wait_reg <= 1'b1;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (wait_reg)
                    begin
                        wait_reg <= 1'b0;
                        first_reg <= 1'b1;
                    end
                    else
                    begin
                        first_reg <= 1'b0;
                        if (sts.done)
                        begin
                            first_reg <= 1'b1;
                            if (lane_reg == 2'd2)
                            begin
                                lane_reg <= 2'd0;
                                state_reg <= S_POS;
                            end
                            else
                                lane_reg <= lane_reg + 2'd1;
                        end
                    end
                end
                S_OUT:
                    if (out_fire) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`include "velocity_friction_integrator_unit_assert.svh"
    `VFI_ASSERT_IMPLY(a_no_accept_busy, clk, rst_n, in_fire, state_reg == S_IDLE)
    `VFI_ASSERT_NEXT(a_accept_loads, clk, rst_n, in_fire, state_reg == S_LOAD)
    `VFI_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_fire, out_valid)
endmodule

>>> tb/tb_top.sv
// self-checking bench for the velocity friction integrator: table of directed items, then random
module tb_top;
    logic         clk = 1'b0;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_idx;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    // req_type
    logic [1:0]   s_tuser;
    // time_step, on_ground, value_x, value_y, value_z, scale_by_time from bit 0 up
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z from bit 0 up
    logic [191:0] m_tdata;

    velocity_friction_integrator_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    localparam int FB = vfi_pkg::FRAC_BITS_DEF;
    localparam int TSF = vfi_pkg::TS_FRAC;
    localparam longint Y_CUT = ((longint'(1) << FB) + 9999) / 10000;
    localparam int WATCHDOG = 20000;

    typedef struct {
        vfi_pkg::req_t req;
        logic [19:0]   step;
        logic          ground;
        logic [31:0]   vx, vy, vz;
        logic          scale;
    } motion_item_t;

    typedef struct {
        motion_item_t it;
        logic         known;   // expected state typed in
        logic [191:0] state;
    } dir_row_t;

    // predictor state
    longint grav_m[3];
    longint fric_m[3];
    longint vel_m[3];
    longint pos_m[3];

    logic [191:0] state_q[$];
    int  errors = 0;
    int  table_err = 0;
    int  mism = 0;
    int  idle_cnt = 0;
    bit  hold_req = 1'b0;
    bit  hold_off = 1'b0;
    bit  stim_done = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // component times step, round half up, saturate
    function automatic longint step_scale(longint c, longint dt);
        longint p;
        p = c * dt + (longint'(1) << (TSF - 1));
        return clip32(p >>> TSF);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned rem, res, b;
        rem = x;
        res = 0;
        b = 64'd1 << 62;
        while (b > rem) b >>= 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned length3(longint a, longint b, longint c);
        longint unsigned s;
        s = longint'(a < 0 ? -a : a) * longint'(a < 0 ? -a : a);
        s += longint'(b < 0 ? -b : b) * longint'(b < 0 ? -b : b);
        s += longint'(c < 0 ? -c : c) * longint'(c < 0 ? -c : c);
        return root_floor(s);
    endfunction

    function automatic longint to_speed(longint c, longint unsigned ns, longint unsigned sp);
        longint unsigned a, q;
        if (sp == 0) return 0;
        a = c < 0 ? -c : c;
        q = (a * ns + sp / 2) / sp;
        return clip32(c < 0 ? -longint'(q) : longint'(q));
    endfunction

    function automatic logic [191:0] pack_state();
        return {vel_m[2][31:0], vel_m[1][31:0], vel_m[0][31:0],
                pos_m[2][31:0], pos_m[1][31:0], pos_m[0][31:0]};
    endfunction

    // advance the predicted state by one item and return the expected result
    function automatic logic [191:0] integrate(motion_item_t it);
        longint dt;
        longint val[3];
        longint unsigned sp, fr, ns;
        longint ay;
        dt = it.step;
        val[0] = longint'($signed(it.vx));
        val[1] = longint'($signed(it.vy));
        val[2] = longint'($signed(it.vz));
        case (it.req)
            vfi_pkg::REQ_TICK:
            begin
                if (!it.ground)
                    for (int i = 0; i < 3; i++)
                        vel_m[i] = clip32(vel_m[i] + step_scale(grav_m[i], dt));
                sp = length3(vel_m[0], vel_m[1], vel_m[2]);
                fr = (length3(fric_m[0], fric_m[1], fric_m[2]) * dt
                      + (64'd1 << (TSF - 1))) >> TSF;
                ns = (sp > fr) ? sp - fr : 0;
                vel_m[0] = to_speed(vel_m[0], ns, sp);
                vel_m[2] = to_speed(vel_m[2], ns, sp);
                ay = vel_m[1] < 0 ? -vel_m[1] : vel_m[1];
                if (ay < Y_CUT) vel_m[1] = 0;
                for (int i = 0; i < 3; i++)
                    pos_m[i] = clip32(pos_m[i] + step_scale(vel_m[i], dt));
            end
            vfi_pkg::REQ_ADD_VEL:
                for (int i = 0; i < 3; i++)
                    vel_m[i] = clip32(vel_m[i] + (it.scale ? step_scale(val[i], dt) : val[i]));
            vfi_pkg::REQ_SET_POS:
                for (int i = 0; i < 3; i++) pos_m[i] = val[i];
            default: ;
        endcase
        return pack_state();
    endfunction

    task automatic write_reg(vfi_pkg::cfg_idx_t idx, logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx <= vfi_pkg::CFG_GZ) grav_m[idx] = longint'($signed(v));
        else fric_m[idx - vfi_pkg::CFG_FX] = longint'($signed(v));
    endtask

    // index past the last register must be ignored
    task automatic write_bad_index(logic [2:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // offer one item from the falling edge and wait until it is taken
    task automatic send_item(motion_item_t it, logic [191:0] exp_state);
        s_tuser <= it.req;
        s_tdata <= {2'b00, it.scale, it.vz, it.vy, it.vx, it.ground, it.step};
        s_tvalid <= 1'b1;
        state_q.push_back(exp_state);
        do @(posedge clk); while (!(s_tready === 1'b1));
        @(negedge clk);
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        drop_valid();
        while (state_q.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);   // a tick can still be in flight
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000);
        endcase
    endfunction

    function automatic motion_item_t rand_item();
        motion_item_t it;
        int k;
        k = $urandom_range(0, 99);
        it.req = k < 60 ? vfi_pkg::REQ_TICK : k < 80 ? vfi_pkg::REQ_ADD_VEL
               : k < 95 ? vfi_pkg::REQ_SET_POS : vfi_pkg::REQ_NONE;
        it.step = $urandom_range(0, 9) == 0 ? 20'($urandom) : 20'($urandom_range(0, 16'h2000));
        it.ground = 1'($urandom);
        it.vx = rand_comp();
        it.vy = rand_comp();
        it.vz = rand_comp();
        it.scale = 1'($urandom);
        return it;
    endfunction

    task automatic random_config(bit extreme);
        for (int r = 0; r < vfi_pkg::N_CFG; r++)
            write_reg(vfi_pkg::cfg_idx_t'(r),
                      extreme ? ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000)
                              : 32'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000));
    endtask

    // directed table
    dir_row_t dir_rows[$];

    function automatic motion_item_t mk(vfi_pkg::req_t r, logic [19:0] s, logic g,
                                        logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic sc);
        motion_item_t it;
        it.req = r; it.step = s; it.ground = g;
        it.vx = x; it.vy = y; it.vz = z; it.scale = sc;
        return it;
    endfunction

    function automatic void add_row(motion_item_t it, logic known, logic [191:0] st);
        dir_row_t d;
        d.it = it; d.known = known; d.state = st;
        dir_rows.push_back(d);
    endfunction

    // stimulus
    initial
    begin
        motion_item_t it;
        logic [191:0] pred;
        int burst;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        for (int i = 0; i < 3; i++)
        begin
            grav_m[i] = 0; fric_m[i] = 0; vel_m[i] = 0; pos_m[i] = 0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero velocity tick right after reset: all zero
        add_row(mk(vfi_pkg::REQ_TICK, 20'h10000, 1'b0, '0, '0, '0, 1'b0), 1'b1, '0);
        add_row(mk(vfi_pkg::REQ_NONE, 20'hfffff, 1'b1, 32'h7fffffff, 32'h7fffffff,
                   32'h7fffffff, 1'b1), 1'b1, '0);
        add_row(mk(vfi_pkg::REQ_SET_POS, 20'h0, 1'b0, 32'h7fffffff, 32'h80000000, 32'h1,
                   1'b0), 1'b1, {96'h0, 32'h1, 32'h80000000, 32'h7fffffff});
        add_row(mk(vfi_pkg::REQ_ADD_VEL, 20'h0, 1'b0, 32'h7fffffff, 32'h80000000, 32'h0,
                   1'b0), 1'b1,
                {32'h0, 32'h80000000, 32'h7fffffff, 32'h1, 32'h80000000, 32'h7fffffff});
        // saturation of velocity and position
        add_row(mk(vfi_pkg::REQ_ADD_VEL, 20'h0, 1'b1, 32'h7fffffff, 32'h80000000,
                   32'h80000000, 1'b0), 1'b0, '0);
        add_row(mk(vfi_pkg::REQ_TICK, 20'hfffff, 1'b1, '0, '0, '0, 1'b0), 1'b0, '0);
        add_row(mk(vfi_pkg::REQ_ADD_VEL, 20'hfffff, 1'b0, 32'h80000000, 32'h7fffffff,
                   32'h12345, 1'b1), 1'b0, '0);
        add_row(mk(vfi_pkg::REQ_SET_POS, 20'h0, 1'b0, '0, '0, '0, 1'b0), 1'b0, '0);
        // small y is cut to zero
        add_row(mk(vfi_pkg::REQ_ADD_VEL, 20'h0, 1'b0, 32'h0, 32'h3, 32'h0, 1'b0), 1'b0, '0);
        add_row(mk(vfi_pkg::REQ_TICK, 20'h1000, 1'b1, '0, '0, '0, 1'b0), 1'b0, '0);
        add_row(mk(vfi_pkg::REQ_TICK, 20'h0, 1'b0, '0, '0, '0, 1'b1), 1'b0, '0);
        add_row(mk(vfi_pkg::REQ_ADD_VEL, 20'h8000, 1'b0, 32'h30000, 32'hfffc0000, 32'h40000,
                   1'b1), 1'b0, '0);
        add_row(mk(vfi_pkg::REQ_TICK, 20'h4000, 1'b0, 32'hffffffff, '1, '1, 1'b1), 1'b0, '0);

        foreach (dir_rows[i])
        begin
            pred = integrate(dir_rows[i].it);
            if (dir_rows[i].known && pred !== dir_rows[i].state)
            begin
                table_err++;
                $display("directed row %0d: table %h predictor %h", i, dir_rows[i].state, pred);
            end
            send_item(dir_rows[i].it, dir_rows[i].known ? dir_rows[i].state : pred);
        end
        wait_drain();

        // friction and gravity, then six ticks, the last three on the ground
        write_reg(vfi_pkg::CFG_GX, 32'h0);
        write_reg(vfi_pkg::CFG_GY, 32'hfff60000);
        write_reg(vfi_pkg::CFG_GZ, 32'h0);
        write_reg(vfi_pkg::CFG_FX, 32'h20000);
        write_reg(vfi_pkg::CFG_FY, 32'h0);
        write_reg(vfi_pkg::CFG_FZ, 32'h10000);
        write_bad_index(3'(vfi_pkg::N_CFG), 32'hdeadbeef);
        write_bad_index(3'(vfi_pkg::N_CFG + 1), 32'h7fffffff);
        for (int i = 0; i < 6; i++)
        begin
            it = mk(vfi_pkg::REQ_TICK, 20'h4000, i > 2, '0, '0, '0, 1'b0);
            send_item(it, integrate(it));
        end
        wait_drain();

        // random phases, with extreme settings in two of them
        for (int ph = 0; ph < 7; ph++)
        begin
            random_config(ph == 2 || ph == 5);
            for (int n = 0; n < 250; )
            begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 250; b++, n++)
                begin
                    if (ph == 3 && n == 40) hold_req = 1'b1;   // receiver holds off, input stalls
                    it = rand_item();
                    send_item(it, integrate(it));
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    drop_valid();
                    repeat ($urandom_range(1, 30)) @(negedge clk);
                end
            end
            wait_drain();
        end
        stim_done = 1'b1;
    end

    // long hold-off counted here
    initial
    begin
        wait (hold_req);
        hold_off = 1'b1;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
    end

    // receiver stall pattern
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off) m_tready <= 1'b0;
            else m_tready <= ($urandom_range(0, 7) < 5) || ($urandom_range(0, 63) < 2);
        end
    end

    // result check at the rising edge
    always @(posedge clk)
    begin
        logic [191:0] exp_state;
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (state_q.size() == 0)
            begin
                errors++;
                if (mism < 10) $display("unexpected result %h", m_tdata);
                mism++;
            end
            else
            begin
                exp_state = state_q.pop_front();
                for (int f = 0; f < 6; f++)
                    if (m_tdata[f*32 +: 32] !== exp_state[f*32 +: 32])
                    begin
                        errors++;
                        if (mism < 10)
                            $display("field %0d: expected %h got %h", f,
                                     exp_state[f*32 +: 32], m_tdata[f*32 +: 32]);
                        mism++;
                    end
            end
        end
    end

    // watchdog on cycles with no item accepted or result taken while work is pending
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !s_tvalid && state_q.size() == 0
            || hold_off)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
    end

    initial
    begin
        fork
            wait (idle_cnt >= WATCHDOG);
            wait (stim_done);
        join_any
        if (!stim_done || state_q.size() != 0 || errors != 0 || table_err != 0)
            $display("status: fail");
        else
            $display("status: pass");
        $finish;
    end
endmodule
